>>> rtl/nts_pkg.sv
// ----------------------------------------------------------------------------
// Nearest texel sampler package
// Shared widths, codes and request/result types of the texture sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package nts_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned TEXEL_W    = 32;
  localparam int unsigned MAX_TEXELS = 65536;

  // Width of a computed texel address: (2^DIM_W - 1)^2 plus a column still fits.
  localparam int unsigned ADDR_CALC_W = 2 * DIM_W + 1;
  // Width used to compare addresses against the store depth (depth up to 2^24).
  localparam int unsigned CMP_W       = 25;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_TEX_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TEX_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WRAP_MODE  = 2'd2;

  localparam logic [TEXEL_W-1:0] WHITE_TEXEL = '1;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_type_e;

  typedef enum logic {
    WRAP_REPEAT = 1'b0,
    WRAP_MIRROR = 1'b1
  } wrap_mode_e;

  typedef struct packed {
    req_type_e                  req_type;
    logic [INDEX_W-1:0]         texel_index;
    logic [TEXEL_W-1:0]         texel_value;
    logic signed [COORD_W-1:0]  u_coord;
    logic signed [COORD_W-1:0]  v_coord;
  } req_t;

  typedef struct packed {
    logic [TEXEL_W-1:0] sample_color;
    logic               used_default;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0] tex_width;
    logic [DIM_W-1:0] tex_height;
    wrap_mode_e       wrap_mode;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/nts_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/nts_cfg.sv
// ----------------------------------------------------------------------------
// Sampler configuration registers
// APB register file holding texture width, height and wrap mode.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nts_pkg::PADDR_W-1:0]    paddr,
  input  logic [nts_pkg::APB_DATA_W-1:0] pwdata,
  output logic [nts_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output nts_pkg::cfg_t                  cfg_o
);

  import nts_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  cfg_t                 cfg_q;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tex_width  <= '0;
      cfg_q.tex_height <= '0;
      cfg_q.wrap_mode  <= WRAP_REPEAT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TEX_WIDTH:  cfg_q.tex_width  <= pwdata[DIM_W-1:0];
        REG_TEX_HEIGHT: cfg_q.tex_height <= pwdata[DIM_W-1:0];
        REG_WRAP_MODE:  cfg_q.wrap_mode  <= wrap_mode_e'(pwdata[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEX_WIDTH:  prdata = APB_DATA_W'(cfg_q.tex_width);
      REG_TEX_HEIGHT: prdata = APB_DATA_W'(cfg_q.tex_height);
      REG_WRAP_MODE:  prdata = APB_DATA_W'(cfg_q.wrap_mode);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/nts_wrap.sv
// ----------------------------------------------------------------------------
// Coordinate wrap unit
// Wraps one fixed-point coordinate into the unit tile and scales it to a
// clamped texel index along one axis.
// ----------------------------------------------------------------------------
`default_nettype none

module nts_wrap (
  input  logic signed [nts_pkg::COORD_W-1:0] coord_i,
  input  logic [nts_pkg::DIM_W-1:0]          dim_i,
  input  nts_pkg::wrap_mode_e                wrap_mode_i,
  output logic [nts_pkg::DIM_W-1:0]          idx_o
);

  import nts_pkg::*;

  localparam int unsigned ProdW = FRAC_BITS + 1 + DIM_W;

  logic [FRAC_BITS-1:0] frac;
  logic                 odd_tile;
  logic [FRAC_BITS:0]   scale;
  logic [ProdW-1:0]     prod;
  logic [DIM_W:0]       pix;

  assign frac     = coord_i[FRAC_BITS-1:0];
  assign odd_tile = coord_i[FRAC_BITS];

  // Mirrored repeat reflects the fraction on odd tiles.
  always_comb begin
    if ((wrap_mode_i == WRAP_MIRROR) && odd_tile) begin
      scale = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
    end else begin
      scale = {1'b0, frac};
    end
  end

  assign prod = {{DIM_W{1'b0}}, scale} * {{(FRAC_BITS + 1){1'b0}}, dim_i};
  assign pix  = prod[ProdW-1:FRAC_BITS];

  always_comb begin
    if (pix >= {1'b0, dim_i}) begin
      idx_o = dim_i - DIM_W'(1);
    end else begin
      idx_o = pix[DIM_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/nearest_texel_sampler.sv
// ----------------------------------------------------------------------------
// Nearest texel sampler
// Texture store with nearest-neighbor sampling, repeat or mirrored repeat.
// ----------------------------------------------------------------------------
//
//   port group      direction  handshake                    payload
//   request         in         start, busy                  req_i (req_t)
//   result          out        result_valid_o (strobe)      result_o (result_t)
//   configuration   in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One request is taken every cycle; busy is never raised. A sample's result is
// registered after the wrap multipliers, after the row-times-width address
// multiplier and after the store read. Texel writes pass down the same pipeline
// and hit the store in order with samples, so a sample always sees every
// earlier write. Writes give no result. Reset clears the configuration registers
// and the pipeline valid bits; the store is not cleared. The result strobe lasts
// one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_texel_sampler #(
  parameter int unsigned MaxTexels = nts_pkg::MAX_TEXELS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  nts_pkg::req_t                  req_i,
  output logic                           result_valid_o,
  output nts_pkg::result_t               result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nts_pkg::PADDR_W-1:0]    paddr,
  input  logic [nts_pkg::APB_DATA_W-1:0] pwdata,
  output logic [nts_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  import nts_pkg::*;

  localparam int unsigned StoreAddrW = (MaxTexels > 1) ? $clog2(MaxTexels) : 1;

  cfg_t cfg;
  logic accept;

  nts_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Stage 1: wrapped column and row.
  logic [DIM_W-1:0] col_d, row_d;

  nts_wrap u_wrap_u (
    .coord_i     (req_i.u_coord),
    .dim_i       (cfg.tex_width),
    .wrap_mode_i (cfg.wrap_mode),
    .idx_o       (col_d)
  );

  nts_wrap u_wrap_v (
    .coord_i     (req_i.v_coord),
    .dim_i       (cfg.tex_height),
    .wrap_mode_i (cfg.wrap_mode),
    .idx_o       (row_d)
  );

  logic               s1_valid_q;
  req_type_e          s1_type_q;
  logic               s1_empty_q;
  logic [DIM_W-1:0]   s1_col_q, s1_row_q;
  logic [INDEX_W-1:0] s1_index_q;
  logic [TEXEL_W-1:0] s1_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_type_q  <= req_i.req_type;
      s1_empty_q <= (cfg.tex_width == '0) | (cfg.tex_height == '0);
      s1_col_q   <= col_d;
      s1_row_q   <= row_d;
      s1_index_q <= req_i.texel_index;
      s1_value_q <= req_i.texel_value;
    end
  end

  // Stage 2: flipped linear address for samples (texel index for writes) and range check.
  logic [DIM_W-1:0]       flip_row;
  logic [2*DIM_W-1:0]     row_base;
  logic [ADDR_CALC_W-1:0] addr_d;
  logic [CMP_W-1:0]       addr_ext_d;
  logic                   in_range;
  logic                   hit_d;

  assign flip_row = cfg.tex_height - DIM_W'(1) - s1_row_q;
  assign row_base = {{DIM_W{1'b0}}, flip_row} * {{DIM_W{1'b0}}, cfg.tex_width};

  always_comb begin
    if (s1_type_q == REQ_WRITE) begin
      addr_d = {{(ADDR_CALC_W - INDEX_W){1'b0}}, s1_index_q};
    end else begin
      addr_d = {1'b0, row_base} + {{(ADDR_CALC_W - DIM_W){1'b0}}, s1_col_q};
    end
  end

  assign addr_ext_d = {{(CMP_W - ADDR_CALC_W){1'b0}}, addr_d};
  assign in_range   = addr_ext_d < CMP_W'(MaxTexels);
  assign hit_d      = in_range & ((s1_type_q == REQ_WRITE) | ~s1_empty_q);

  logic                   s2_valid_q;
  req_type_e              s2_type_q;
  logic                   s2_hit_q;
  logic [ADDR_CALC_W-1:0] s2_addr_q;
  logic [TEXEL_W-1:0]     s2_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_type_q  <= s1_type_q;
      s2_hit_q   <= hit_d;
      s2_addr_q  <= addr_d;
      s2_value_q <= s1_value_q;
    end
  end

  // Stage 3: store access, one write or one read per cycle.
  logic                  ram_en, ram_we;
  logic [CMP_W-1:0]      ram_addr_ext;
  logic [StoreAddrW-1:0] ram_addr;
  logic [TEXEL_W-1:0]    ram_rdata;

  assign ram_en       = s2_valid_q & s2_hit_q;
  assign ram_we       = s2_type_q == REQ_WRITE;
  assign ram_addr_ext = {{(CMP_W - ADDR_CALC_W){1'b0}}, s2_addr_q};
  assign ram_addr     = ram_addr_ext[StoreAddrW-1:0];

  nts_ram #(
    .Width (TEXEL_W),
    .Depth (MaxTexels)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (s2_value_q),
    .rdata_o (ram_rdata)
  );

  logic s3_valid_q;
  logic s3_dflt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q & (s2_type_q == REQ_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_dflt_q <= ~s2_hit_q;
    end
  end

  assign result_valid_o        = s3_valid_q;
  assign result_o.sample_color = s3_dflt_q ? WHITE_TEXEL : ram_rdata;
  assign result_o.used_default = s3_dflt_q;

endmodule

`default_nettype wire
